// ===== hw/rtl/manifest_varint_record_decoder_defines.svh =====
// Assertion macros used by the checker file mvrd_checker.sv.
`ifndef MANIFEST_VARINT_RECORD_DECODER_DEFINES_SVH
`define MANIFEST_VARINT_RECORD_DECODER_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define MVRD_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define MVRD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define MVRD_CHECK_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mvrd_pkg.sv =====
package mvrd_pkg;

  typedef enum logic [1:0] {
    KIND_NODE    = 2'd0,
    KIND_CONTRIB = 2'd1,
    KIND_OK      = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TRUNCATED  = 3'd1,
    ERR_OVERLONG   = 3'd2,
    ERR_ID_RANGE   = 3'd3,
    ERR_PARENT     = 3'd4,
    ERR_TRAILING   = 3'd5,
    ERR_SHORT_HASH = 3'd6
  } err_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } opcode_t;

  localparam logic CFG_NODE_TOTAL    = 1'b0;
  localparam logic CFG_CONTRIB_TOTAL = 1'b1;

  localparam logic [7:0] VARINT_PAYLOAD_MASK = 8'h7f;
  localparam logic [3:0] VARINT_LAST_INDEX   = 4'd9;
  localparam logic [2:0] HASH_LAST_INDEX     = 3'd7;

endpackage

// ===== hw/rtl/manifest_varint_record_decoder.sv =====
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// in       | in_valid / in_ready   | in_opcode, in_data_byte
// out      | out_valid / out_ready | out_kind, out_file_id, out_parent_index,
//          |                       | out_line_number, out_row_hash, out_error_code
// cfg      | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One word per cycle while in_ready is high: each word updates the decode state in the cycle
// it is taken, and a result shows on out_ valid in the next cycle from the output register.
// in_ready is low only while a result sits in the output register and out_ready is low.
// rst_n is synchronous, active low; it clears the decode state and both totals.
module manifest_varint_record_decoder #(
  parameter int ID_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_file_id,
  output logic [31:0] out_parent_index,
  output logic [31:0] out_line_number,
  output logic [63:0] out_row_hash,
  output logic [2:0]  out_error_code,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [63:0] ID_LIMIT =
    (ID_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ID_WIDTH) - 64'd1);

  logic [31:0]     node_total_r, contrib_total_r;
  logic            second_r, second_nxt;
  logic [1:0]      field_pos_r, field_pos_nxt;
  logic [63:0]     vacc_r, vacc_nxt;
  logic [3:0]      vidx_r, vidx_nxt;
  logic [31:0]     rec_done_r, rec_done_nxt;
  logic [31:0]     held_id_r, held_id_nxt;
  logic            held_id_big_r, held_id_big_nxt;
  logic [31:0]     held_parent_r, held_parent_nxt;
  logic            held_parent_bad_r, held_parent_bad_nxt;
  logic [2:0]      hidx_r, hidx_nxt;
  logic [63:0]     hacc_r, hacc_nxt;
  mvrd_pkg::err_t  sticky_r, sticky_nxt;

  logic            out_valid_r;
  mvrd_pkg::kind_t out_kind_r, res_kind;
  logic [31:0]     out_file_id_r, res_file_id;
  logic [31:0]     out_parent_r, res_parent;
  logic [31:0]     out_line_r, res_line;
  logic [63:0]     out_hash_r, res_hash;
  mvrd_pkg::err_t  out_err_r, res_err;
  logic            res_emit;

  logic            accept;
  logic [31:0]     total;
  logic [63:0]     vshift, vval, hval;
  logic [6:0]      vshamt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign total    = second_r ? contrib_total_r : node_total_r;
  assign vshamt   = 7'(vidx_r) * 7'd7;
  assign vshift   = {56'd0, in_data_byte & mvrd_pkg::VARINT_PAYLOAD_MASK} << vshamt;
  assign vval     = vacc_r | vshift;
  assign hval     = hacc_r | ({56'd0, in_data_byte} << {hidx_r, 3'b000});

  always_comb begin
    second_nxt          = second_r;
    field_pos_nxt       = field_pos_r;
    vacc_nxt            = vacc_r;
    vidx_nxt            = vidx_r;
    rec_done_nxt        = rec_done_r;
    held_id_nxt         = held_id_r;
    held_id_big_nxt     = held_id_big_r;
    held_parent_nxt     = held_parent_r;
    held_parent_bad_nxt = held_parent_bad_r;
    hidx_nxt            = hidx_r;
    hacc_nxt            = hacc_r;
    sticky_nxt          = sticky_r;
    res_emit            = 1'b0;
    res_kind            = mvrd_pkg::KIND_ERROR;
    res_file_id         = '0;
    res_parent          = '0;
    res_line            = '0;
    res_hash            = '0;
    res_err             = mvrd_pkg::ERR_NONE;

    if (accept) begin
      if (in_opcode == mvrd_pkg::OP_END) begin
        res_emit = 1'b1;
        if (sticky_r != mvrd_pkg::ERR_NONE) begin
          res_err = sticky_r;
        end else if (second_r && field_pos_r == 2'd1) begin
          res_err = mvrd_pkg::ERR_SHORT_HASH;
        end else if (field_pos_r != 2'd0 || vidx_r != 4'd0 || rec_done_r < total) begin
          res_err = mvrd_pkg::ERR_TRUNCATED;
        end else begin
          res_kind            = mvrd_pkg::KIND_OK;
          second_nxt          = 1'b1;
          rec_done_nxt        = '0;
          field_pos_nxt       = '0;
          vacc_nxt            = '0;
          vidx_nxt            = '0;
          held_id_nxt         = '0;
          held_id_big_nxt     = 1'b0;
          held_parent_nxt     = '0;
          held_parent_bad_nxt = 1'b0;
          hidx_nxt            = '0;
          hacc_nxt            = '0;
        end
      end else if (sticky_r == mvrd_pkg::ERR_NONE) begin
        if (rec_done_r >= total) begin
          res_emit = 1'b1;
          res_err  = mvrd_pkg::ERR_TRAILING;
        end else if (second_r && field_pos_r == 2'd1) begin
          if (hidx_r == mvrd_pkg::HASH_LAST_INDEX) begin
            res_emit      = 1'b1;
            res_kind      = mvrd_pkg::KIND_CONTRIB;
            res_file_id   = held_id_r;
            res_hash      = hval;
            rec_done_nxt  = rec_done_r + 32'd1;
            field_pos_nxt = '0;
            vacc_nxt      = '0;
            vidx_nxt      = '0;
            held_id_nxt   = '0;
            hidx_nxt      = '0;
            hacc_nxt      = '0;
          end else begin
            hidx_nxt = hidx_r + 3'd1;
            hacc_nxt = hval;
          end
        end else if (vidx_r >= mvrd_pkg::VARINT_LAST_INDEX && in_data_byte > 8'd1) begin
          res_emit = 1'b1;
          res_err  = mvrd_pkg::ERR_OVERLONG;
        end else if (in_data_byte[7]) begin
          vacc_nxt = vval;
          vidx_nxt = vidx_r + 4'd1;
        end else begin
          vacc_nxt = '0;
          vidx_nxt = '0;
          if (second_r) begin
            if (vval > ID_LIMIT) begin
              res_emit = 1'b1;
              res_err  = mvrd_pkg::ERR_ID_RANGE;
            end else begin
              held_id_nxt   = vval[31:0];
              field_pos_nxt = 2'd1;
              hidx_nxt      = '0;
              hacc_nxt      = '0;
            end
          end else if (field_pos_r == 2'd0) begin
            held_id_nxt     = vval[31:0];
            held_id_big_nxt = vval > ID_LIMIT;
            field_pos_nxt   = 2'd1;
          end else if (field_pos_r == 2'd1) begin
            held_parent_nxt     = vval[31:0];
            held_parent_bad_nxt = vval > {32'd0, node_total_r};
            field_pos_nxt       = 2'd2;
          end else if (held_id_big_r || vval[63:32] != 32'd0) begin
            res_emit = 1'b1;
            res_err  = mvrd_pkg::ERR_ID_RANGE;
          end else if (held_parent_bad_r) begin
            res_emit = 1'b1;
            res_err  = mvrd_pkg::ERR_PARENT;
          end else begin
            res_emit            = 1'b1;
            res_kind            = mvrd_pkg::KIND_NODE;
            res_file_id         = held_id_r;
            res_parent          = held_parent_r - 32'd1;
            res_line            = vval[31:0];
            rec_done_nxt        = rec_done_r + 32'd1;
            field_pos_nxt       = '0;
            held_id_nxt         = '0;
            held_id_big_nxt     = 1'b0;
            held_parent_nxt     = '0;
            held_parent_bad_nxt = 1'b0;
            hidx_nxt            = '0;
            hacc_nxt            = '0;
          end
        end
      end
      if (res_emit && res_kind == mvrd_pkg::KIND_ERROR) begin
        sticky_nxt = res_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_total_r      <= '0;
      contrib_total_r   <= '0;
      second_r          <= 1'b0;
      field_pos_r       <= '0;
      vacc_r            <= '0;
      vidx_r            <= '0;
      rec_done_r        <= '0;
      held_id_r         <= '0;
      held_id_big_r     <= 1'b0;
      held_parent_r     <= '0;
      held_parent_bad_r <= 1'b0;
      hidx_r            <= '0;
      hacc_r            <= '0;
      sticky_r          <= mvrd_pkg::ERR_NONE;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mvrd_pkg::CFG_NODE_TOTAL) begin
          node_total_r <= cfg_wdata;
        end else begin
          contrib_total_r <= cfg_wdata;
        end
      end
      second_r          <= second_nxt;
      field_pos_r       <= field_pos_nxt;
      vacc_r            <= vacc_nxt;
      vidx_r            <= vidx_nxt;
      rec_done_r        <= rec_done_nxt;
      held_id_r         <= held_id_nxt;
      held_id_big_r     <= held_id_big_nxt;
      held_parent_r     <= held_parent_nxt;
      held_parent_bad_r <= held_parent_bad_nxt;
      hidx_r            <= hidx_nxt;
      hacc_r            <= hacc_nxt;
      sticky_r          <= sticky_nxt;
      if (res_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (res_emit) begin
      out_kind_r    <= res_kind;
      out_file_id_r <= res_file_id;
      out_parent_r  <= res_parent;
      out_line_r    <= res_line;
      out_hash_r    <= res_hash;
      out_err_r     <= res_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_file_id      = out_file_id_r;
  assign out_parent_index = out_parent_r;
  assign out_line_number  = out_line_r;
  assign out_row_hash     = out_hash_r;
  assign out_error_code   = out_err_r;

endmodule

// ===== hw/rtl/mvrd_checker.sv =====
`include "manifest_varint_record_decoder_defines.svh"

module mvrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_file_id,
  input logic [31:0] out_parent_index,
  input logic [31:0] out_line_number,
  input logic [63:0] out_row_hash,
  input logic [2:0]  out_error_code
);

  `MVRD_CHECK_RST(a_idle_after_reset, !rst_n, !out_valid, "out_valid set after reset")

  `MVRD_CHECK_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_kind) && $stable(out_error_code)
                   && $stable(out_file_id), "stalled word changed")

  `MVRD_CHECK(a_err_kind, out_valid,
              (out_kind == mvrd_pkg::KIND_ERROR) == (out_error_code != mvrd_pkg::ERR_NONE),
              "error code and kind disagree")

  `MVRD_CHECK(a_node_fields, out_valid && out_kind != mvrd_pkg::KIND_NODE,
              out_parent_index == 32'd0 && out_line_number == 32'd0,
              "node fields set on other word")

  `MVRD_CHECK(a_status_fields,
              out_valid && (out_kind == mvrd_pkg::KIND_OK || out_kind == mvrd_pkg::KIND_ERROR),
              out_file_id == 32'd0 && out_row_hash == 64'd0, "record fields set on status word")

endmodule

bind manifest_varint_record_decoder mvrd_checker u_mvrd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_file_id      (out_file_id),
  .out_parent_index (out_parent_index),
  .out_line_number  (out_line_number),
  .out_row_hash     (out_row_hash),
  .out_error_code   (out_error_code)
);

// ===== bench/tb_manifest_varint_record_decoder.sv =====
`timescale 1ns / 1ps

module tb_manifest_varint_record_decoder;

  localparam int ID_WIDTH = 32;
  localparam logic [63:0] ID_MAX = (64'd1 << ID_WIDTH) - 64'd1;
  localparam logic [63:0] LINE_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int NODES_PER_PHASE = 50;
  localparam int CONTRIBS_PER_PHASE = 40;
  localparam int DIR_NODES = 2;
  localparam int TIMEOUT_NS = 2_000_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] file_id;
    logic [31:0] parent;
    logic [31:0] line;
    logic [63:0] hash;
    logic [2:0]  err;
  } rec_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;
    rec_t       res;
  } dir_row_t;

  typedef enum int {
    CLOSE_CLEAN,
    CLOSE_TRUNCATED,
    CLOSE_OVERLONG,
    CLOSE_CONTRIB_ID,
    CLOSE_SHORT_HASH,
    CLOSE_NODE_RANGE,
    CLOSE_PARENT
  } closing_t;

  // root node with a zero-padded ten-byte line, then a node with all fields at max
  localparam dir_row_t DIR_TABLE [27] = '{
    '{mvrd_pkg::OP_BYTE, 8'h00, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'h00, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h80, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h00, 1'b1,
      '{mvrd_pkg::KIND_NODE, 32'h0, 32'hFFFF_FFFF, 32'h0, 64'h0, mvrd_pkg::ERR_NONE}},
    '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h0F, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h0F, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0}, '{mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0},
    '{mvrd_pkg::OP_BYTE, 8'h0F, 1'b1,
      '{mvrd_pkg::KIND_NODE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 64'h0,
        mvrd_pkg::ERR_NONE}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [31:0] out_file_id;
  logic [31:0] out_parent_index;
  logic [31:0] out_line_number;
  logic [63:0] out_row_hash;
  logic [2:0]  out_error_code;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  manifest_varint_record_decoder #(.ID_WIDTH(ID_WIDTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_file_id      (out_file_id),
    .out_parent_index (out_parent_index),
    .out_line_number  (out_line_number),
    .out_row_hash     (out_row_hash),
    .out_error_code   (out_error_code),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // decoder state as the block should hold it
  logic [31:0] node_limit = '0;
  logic [31:0] contrib_limit = '0;
  logic        sect2 = 1'b0;
  logic [1:0]  fld_pos = '0;
  logic [63:0] var_acc = '0;
  logic [3:0]  var_idx = '0;
  logic [31:0] rec_count = '0;
  logic [31:0] hold_id = '0;
  logic        hold_id_big = 1'b0;
  logic [31:0] hold_par = '0;
  logic        hold_par_bad = 1'b0;
  logic [2:0]  hash_idx = '0;
  logic [63:0] hash_acc = '0;
  logic [2:0]  held_err = mvrd_pkg::ERR_NONE;

  rec_t decoded_fifo [$];
  int   mismatch_count = 0;
  int   word_count = 0;
  int   n_node = 0;
  int   n_contrib = 0;
  int   n_ok = 0;
  int   n_err = 0;
  int   send_idle = 14;
  int   recv_idle = 84;

  function automatic void clear_rec();
    fld_pos = '0;
    var_acc = '0;
    var_idx = '0;
    hold_id = '0;
    hold_id_big = 1'b0;
    hold_par = '0;
    hold_par_bad = 1'b0;
    hash_idx = '0;
    hash_acc = '0;
  endfunction

  function automatic bit flag_error(input logic [2:0] code, output rec_t r);
    held_err = code;
    r = '0;
    r.kind = mvrd_pkg::KIND_ERROR;
    r.err = code;
    return 1'b1;
  endfunction

  function automatic bit decode_word(input logic op, input logic [7:0] b, output rec_t r);
    logic [31:0] total;
    logic [63:0] v;
    r = '0;
    total = sect2 ? contrib_limit : node_limit;
    if (op == mvrd_pkg::OP_END) begin
      if (held_err != mvrd_pkg::ERR_NONE) begin
        r.kind = mvrd_pkg::KIND_ERROR;
        r.err = held_err;
        return 1'b1;
      end
      if (sect2 && fld_pos == 2'd1) return flag_error(mvrd_pkg::ERR_SHORT_HASH, r);
      if (fld_pos != 2'd0 || var_idx != 4'd0 || rec_count < total)
        return flag_error(mvrd_pkg::ERR_TRUNCATED, r);
      sect2 = 1'b1;
      rec_count = '0;
      clear_rec();
      r.kind = mvrd_pkg::KIND_OK;
      return 1'b1;
    end

    if (held_err != mvrd_pkg::ERR_NONE) return 1'b0;
    if (rec_count >= total) return flag_error(mvrd_pkg::ERR_TRAILING, r);

    if (sect2 && fld_pos == 2'd1) begin
      hash_acc |= 64'(b) << (hash_idx * 8);
      if (hash_idx == mvrd_pkg::HASH_LAST_INDEX) begin
        r.kind = mvrd_pkg::KIND_CONTRIB;
        r.file_id = hold_id;
        r.hash = hash_acc;
        rec_count++;
        clear_rec();
        return 1'b1;
      end
      hash_idx++;
      return 1'b0;
    end

    if (var_idx >= mvrd_pkg::VARINT_LAST_INDEX && b > 8'd1)
      return flag_error(mvrd_pkg::ERR_OVERLONG, r);
    var_acc |= 64'(b & mvrd_pkg::VARINT_PAYLOAD_MASK) << (var_idx * 7);
    if (b[7]) begin
      var_idx++;
      return 1'b0;
    end
    v = var_acc;
    var_acc = '0;
    var_idx = '0;

    if (sect2) begin
      if (v > ID_MAX) return flag_error(mvrd_pkg::ERR_ID_RANGE, r);
      hold_id = v[31:0];
      fld_pos = 2'd1;
      hash_idx = '0;
      hash_acc = '0;
      return 1'b0;
    end
    if (fld_pos == 2'd0) begin
      hold_id = v[31:0];
      hold_id_big = v > ID_MAX;
      fld_pos = 2'd1;
      return 1'b0;
    end
    if (fld_pos == 2'd1) begin
      hold_par = v[31:0];
      hold_par_bad = v > {32'h0, node_limit};
      fld_pos = 2'd2;
      return 1'b0;
    end
    if (hold_id_big || v > LINE_MAX) return flag_error(mvrd_pkg::ERR_ID_RANGE, r);
    if (hold_par_bad) return flag_error(mvrd_pkg::ERR_PARENT, r);
    r.kind = mvrd_pkg::KIND_NODE;
    r.file_id = hold_id;
    r.parent = hold_par - 32'd1;
    r.line = v[31:0];
    rec_count++;
    clear_rec();
    return 1'b1;
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return 64'($urandom_range(0, 127));
      2: return 64'($urandom_range(0, 16383));
      3: return LINE_MAX;
      default: return {32'h0, 32'($urandom)};
    endcase
  endfunction

  function automatic logic [63:0] pick_big();
    return {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
  endfunction

  function automatic logic [63:0] pick_parent();
    case ($urandom_range(0, 3))
      0: return 64'h0;
      1: return {32'h0, node_limit};
      default: return 64'($urandom_range(0, node_limit));
    endcase
  endfunction

  function automatic logic [63:0] bad_parent();
    if ($urandom_range(0, 1)) return {32'h0, node_limit} + 64'($urandom_range(1, 5));
    return pick_big();
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
  endfunction

  task automatic send_word(input logic op, input logic [7:0] b, input bit typed,
                           input rec_t want);
    rec_t r;
    bit   has;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    has = decode_word(op, b, r);
    if (typed) decoded_fifo.insert(decoded_fifo.size(), want);
    else if (has) decoded_fifo.insert(decoded_fifo.size(), r);
    word_count++;
  endtask

  task automatic send_varint(input logic [63:0] v, input int pad);
    int          len;
    logic [63:0] rest;
    len = 1;
    rest = v >> 7;
    while (rest != 0) begin
      len++;
      rest = rest >> 7;
    end
    len = len + pad;
    if (len > 10) len = 10;
    for (int i = 0; i < len; i++)
      send_word(mvrd_pkg::OP_BYTE, {i < len - 1, 7'(v >> (7 * i))}, 1'b0, '0);
  endtask

  task automatic send_node(input logic [63:0] id, input logic [63:0] par1,
                           input logic [63:0] line);
    send_varint(id, pick_pad());
    send_varint(par1, pick_pad());
    send_varint(line, pick_pad());
  endtask

  task automatic send_contrib(input logic [63:0] id, input int nbytes);
    send_varint(id, pick_pad());
    repeat (nbytes) begin
      case ($urandom_range(0, 7))
        0: send_word(mvrd_pkg::OP_BYTE, 8'h00, 1'b0, '0);
        1: send_word(mvrd_pkg::OP_BYTE, 8'hFF, 1'b0, '0);
        default: send_word(mvrd_pkg::OP_BYTE, 8'($urandom), 1'b0, '0);
      endcase
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mvrd_pkg::CFG_NODE_TOTAL) node_limit = val;
    else contrib_limit = val;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_fifo.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : watch_out
    rec_t want;
    if (rst_n && out_valid && out_ready) begin
      case (out_kind)
        mvrd_pkg::KIND_NODE:    n_node++;
        mvrd_pkg::KIND_CONTRIB: n_contrib++;
        mvrd_pkg::KIND_OK:      n_ok++;
        default:                n_err++;
      endcase
      if (decoded_fifo.size() == 0) begin
        $display("%0t ns: unexpected word, kind %0d error_code %0d", $time, out_kind,
                 out_error_code);
        mismatch_count++;
      end else begin
        want = decoded_fifo.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_kind));
        check_field("file_id", 64'(want.file_id), 64'(out_file_id));
        check_field("parent_index", 64'(want.parent), 64'(out_parent_index));
        check_field("line_number", 64'(want.line), 64'(out_line_number));
        check_field("row_hash", want.hash, out_row_hash);
        check_field("error_code", 64'(want.err), 64'(out_error_code));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    closing_t closing;
    bit       in_nodes;
    in_valid = 1'b0;
    in_opcode = mvrd_pkg::OP_BYTE;
    in_data_byte = '0;
    cfg_we = 1'b0;
    cfg_index = mvrd_pkg::CFG_NODE_TOTAL;
    cfg_wdata = '0;
    rst_n = 1'b0;
    closing = closing_t'($urandom_range(0, 6));
    in_nodes = (closing == CLOSE_NODE_RANGE) || (closing == CLOSE_PARENT);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(mvrd_pkg::CFG_NODE_TOTAL, 32'hFFFF_FFFF);
    write_reg(mvrd_pkg::CFG_CONTRIB_TOTAL, 32'h0);
    for (int i = 0; i < $size(DIR_TABLE); i++)
      send_word(DIR_TABLE[i].op, DIR_TABLE[i].data, DIR_TABLE[i].typed, DIR_TABLE[i].res);
    drain();
    // one spare slot keeps a node error from turning into a trailing byte
    write_reg(mvrd_pkg::CFG_NODE_TOTAL, in_nodes ? DIR_NODES + 3 * NODES_PER_PHASE + 1
                                                 : DIR_NODES + NODES_PER_PHASE);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 14;
          recv_idle = 84;
        end
        1: begin
          send_idle = 84;
          recv_idle = 14;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (ph == 0 || in_nodes)
        repeat (NODES_PER_PHASE) send_node(pick_value(), pick_parent(), pick_value());
      else
        repeat (CONTRIBS_PER_PHASE) send_contrib(pick_value(), 8);
      if (ph == 0 && !in_nodes) begin
        send_word(mvrd_pkg::OP_END, 8'($urandom), 1'b0, '0);
        drain();
        write_reg(mvrd_pkg::CFG_CONTRIB_TOTAL, 32'hFFFF_FFFF);
      end
    end

    case (closing)
      CLOSE_CLEAN: begin
        drain();
        write_reg(mvrd_pkg::CFG_CONTRIB_TOTAL, rec_count);
        send_word(mvrd_pkg::OP_END, 8'($urandom), 1'b0, '0);
        drain();
        write_reg(mvrd_pkg::CFG_CONTRIB_TOTAL, 32'h0);
        write_reg(mvrd_pkg::CFG_NODE_TOTAL, 32'h0);
        send_word(mvrd_pkg::OP_END, 8'($urandom), 1'b0, '0);
        send_word(mvrd_pkg::OP_END, 8'($urandom), 1'b0, '0);
        send_word(mvrd_pkg::OP_BYTE, 8'($urandom), 1'b0, '0);
      end
      CLOSE_TRUNCATED: begin
        if ($urandom_range(0, 1))
          repeat ($urandom_range(1, 9))
            send_word(mvrd_pkg::OP_BYTE, {1'b1, 7'($urandom)}, 1'b0, '0);
        send_word(mvrd_pkg::OP_END, 8'($urandom), 1'b0, '0);
      end
      CLOSE_OVERLONG: begin
        repeat (9) send_word(mvrd_pkg::OP_BYTE, {1'b1, 7'($urandom)}, 1'b0, '0);
        send_word(mvrd_pkg::OP_BYTE, 8'($urandom_range(2, 255)), 1'b0, '0);
      end
      CLOSE_CONTRIB_ID: send_contrib(pick_big(), 8);
      CLOSE_SHORT_HASH: begin
        send_contrib(pick_value(), $urandom_range(0, 7));
        send_word(mvrd_pkg::OP_END, 8'($urandom), 1'b0, '0);
      end
      CLOSE_NODE_RANGE: begin
        if ($urandom_range(0, 1))
          send_node(pick_big(), $urandom_range(0, 1) ? bad_parent() : pick_parent(),
                    pick_value());
        else
          send_node(pick_value(), $urandom_range(0, 1) ? bad_parent() : pick_parent(),
                    pick_big());
      end
      default: send_node(pick_value(), bad_parent(), pick_value());
    endcase

    // error is held: bytes are dropped, end words repeat the code
    repeat ($urandom_range(10, 30))
      send_word(($urandom_range(0, 3) == 0) ? mvrd_pkg::OP_END : mvrd_pkg::OP_BYTE,
                8'($urandom), 1'b0, '0);
    drain();
    repeat (8) @(negedge clk);

    $display("Run covered %0d input words: %0d node, %0d hash, %0d section-ok results,",
             word_count, n_node, n_contrib, n_ok);
    $display("and %0d error results; stream closed with case %s", n_err, closing.name());
    if (mismatch_count == 0 && decoded_fifo.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mvrd_pkg.sv
hw/rtl/manifest_varint_record_decoder.sv
hw/rtl/mvrd_checker.sv
bench/tb_manifest_varint_record_decoder.sv
